// ===== hdl/crenc64_pkg.sv =====
// ----------------------------------------------------------------------------
// crenc64_pkg
// Shared types and constants of the carryless 64-bit range encoder.
// ----------------------------------------------------------------------------
package crenc64_pkg;

  localparam int STATE_W   = 64;
  localparam int COUNT_W   = 32;
  localparam int BYTE_W    = 8;
  localparam int MAX_EMIT  = 8;

  localparam int TOP_BIT_DEF    = 56;
  localparam int BOTTOM_BIT_DEF = 48;

  // input selector carried on in_tuser
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // command kinds handed from the front end to the back end
  localparam logic [1:0] KIND_ENC   = 2'd0;
  localparam logic [1:0] KIND_FLUSH = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]         kind;
    logic [COUNT_W-1:0] sym_lo;  // symbol_low
    logic [COUNT_W-1:0] sym_dl;  // symbol_high - symbol_low
    logic [COUNT_W-1:0] total;   // total_count
  } cmd_t;

endpackage

// ===== hdl/crenc64_front.sv =====
// ----------------------------------------------------------------------------
// crenc64_front
// Accepts input transactions, checks and classifies them, and queues the
// resulting commands for the back end.
// ----------------------------------------------------------------------------
module crenc64_front (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [3*crenc64_pkg::COUNT_W-1:0]         in_tdata,
  input  logic                                      in_tuser,
  output logic                                      q_valid,
  input  logic                                      q_ready,
  output crenc64_pkg::cmd_t                         q_cmd
);

  localparam int CW = crenc64_pkg::COUNT_W;

  crenc64_pkg::cmd_t              q_mem_r [crenc64_pkg::QDEPTH];
  logic [crenc64_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [crenc64_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [crenc64_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  logic [CW-1:0]     slo, shi, tot;
  crenc64_pkg::cmd_t new_cmd;
  logic              push, pop;

  function automatic logic [crenc64_pkg::QCNT_W-1:0] QCNT_W_ONE(input logic b);
    QCNT_W_ONE = {{(crenc64_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign slo = in_tdata[CW-1:0];
  assign shi = in_tdata[2*CW-1:CW];
  assign tot = in_tdata[3*CW-1:2*CW];

  always_comb begin
    new_cmd.sym_lo = slo;
    new_cmd.sym_dl = shi - slo;
    new_cmd.total  = tot;
    priority if (in_tuser == crenc64_pkg::OP_FLUSH) begin
      new_cmd.kind = crenc64_pkg::KIND_FLUSH;
    end else if (tot == '0 || shi <= slo || shi > tot) begin
      new_cmd.kind = crenc64_pkg::KIND_BAD;
    end else begin
      new_cmd.kind = crenc64_pkg::KIND_ENC;
    end
  end

  assign in_tready = (cnt_r != crenc64_pkg::QCNT_W'(crenc64_pkg::QDEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_cmd     = q_mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W_ONE(push) - QCNT_W_ONE(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== hdl/crenc64_back.sv =====
// ----------------------------------------------------------------------------
// crenc64_back
// Executes queued commands: radix-4 range division, split 32x32 multiplies,
// byte emission, flush and rejected-item markers, feeding a registered output stage.
// ----------------------------------------------------------------------------
module crenc64_back #(
  parameter int TOP_BIT    = crenc64_pkg::TOP_BIT_DEF,
  parameter int BOTTOM_BIT = crenc64_pkg::BOTTOM_BIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  crenc64_pkg::cmd_t                  q_cmd,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [crenc64_pkg::BYTE_W-1:0]     out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser
);

  localparam int SW = crenc64_pkg::STATE_W;
  localparam int CW = crenc64_pkg::COUNT_W;
  localparam int BW = crenc64_pkg::BYTE_W;
  localparam int HW = SW / 2;
  localparam int NW = $clog2(crenc64_pkg::MAX_EMIT + 1);
  localparam int DIV_STEPS = SW / 2;
  localparam int DW = $clog2(DIV_STEPS);

  localparam logic [SW-1:0] TOP_MASK = ~((SW'(1) << TOP_BIT) - SW'(1));
  localparam logic [SW-1:0] BOT_LO   = (SW'(1) << BOTTOM_BIT) - SW'(1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV   = 4'd1;
  localparam logic [3:0] ST_M0    = 4'd2;
  localparam logic [3:0] ST_M1    = 4'd3;
  localparam logic [3:0] ST_M2    = 4'd4;
  localparam logic [3:0] ST_M3    = 4'd5;
  localparam logic [3:0] ST_M4    = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;
  localparam logic [3:0] ST_FLUSH = 4'd8;
  localparam logic [3:0] ST_BAD   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [SW-1:0] low_r, low_nxt;
  logic [SW-1:0] range_r, range_nxt;
  logic [SW-1:0] dq_r, dq_nxt;     // dividend in, quotient out
  logic [CW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dcnt_r, dcnt_nxt;
  logic [SW-1:0] prod_r, prod_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [BW-1:0] pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  crenc64_pkg::cmd_t cmd_r, cmd_nxt;

  logic          ov_r, ov_nxt;
  logic [BW-1:0] ob_r, ob_nxt;
  logic          ol_r, ol_nxt;
  logic          obad_r, obad_nxt;

  logic          out_free;
  logic [CW-1:0] mul_a, mul_b;
  logic [SW-1:0] mul_p;
  logic [SW-1:0] prod_fold;
  logic [SW-1:0] low_plus_rng;
  logic          keep_hi, range_small, go;
  logic [SW-1:0] rng_use;
  logic          ge1, ge2;
  logic [CW-1:0] rem1, rem2;
  logic [CW:0]   t1, t2;

  assign out_free = !ov_r || out_tready;
  assign q_ready  = (state_r == ST_IDLE);

  // two restoring division steps per cycle
  always_comb begin
    t1   = {rem_r, dq_r[SW-1]};
    ge1  = (t1 >= {1'b0, cmd_r.total});
    rem1 = ge1 ? CW'(t1 - {1'b0, cmd_r.total}) : t1[CW-1:0];
    t2   = {rem1, dq_r[SW-2]};
    ge2  = (t2 >= {1'b0, cmd_r.total});
    rem2 = ge2 ? CW'(t2 - {1'b0, cmd_r.total}) : t2[CW-1:0];
  end

  // shared 32x32 multiplier, operands chosen by step
  always_comb begin
    unique case (state_r)
      ST_M0:   begin mul_a = cmd_r.sym_lo; mul_b = dq_r[HW-1:0];  end
      ST_M1:   begin mul_a = cmd_r.sym_lo; mul_b = dq_r[SW-1:HW]; end
      ST_M2:   begin mul_a = cmd_r.sym_dl; mul_b = dq_r[HW-1:0];  end
      ST_M3:   begin mul_a = cmd_r.sym_dl; mul_b = dq_r[SW-1:HW]; end
      default: begin mul_a = cmd_r.sym_dl; mul_b = dq_r[SW-1:HW]; end
    endcase
  end

  assign mul_p     = SW'(mul_a) * SW'(mul_b);
  // low word product plus high word product shifted up, modulo 2^64
  assign prod_fold = {acc_r[SW-1:HW] + prod_r[HW-1:0], acc_r[HW-1:0]};

  always_comb begin
    low_plus_rng = low_r + range_r;
    keep_hi      = ((low_r ^ low_plus_rng) & TOP_MASK) == '0;
    range_small  = (range_r & ~BOT_LO) == '0;
    rng_use      = keep_hi ? range_r : ((SW'(0) - low_r) & BOT_LO);
    go           = (n_r != NW'(crenc64_pkg::MAX_EMIT)) && (keep_hi || range_small);
  end

  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    range_nxt  = range_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    n_nxt      = n_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    cmd_nxt    = cmd_r;
    ov_nxt     = ov_r && !out_tready;
    ob_nxt     = ob_r;
    ol_nxt     = ol_r;
    obad_nxt   = obad_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cmd_nxt    = q_cmd;
          dq_nxt     = range_r;
          rem_nxt    = '0;
          dcnt_nxt   = '0;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          unique case (q_cmd.kind)
            crenc64_pkg::KIND_ENC:   state_nxt = ST_DIV;
            crenc64_pkg::KIND_FLUSH: state_nxt = ST_FLUSH;
            default:                 state_nxt = ST_BAD;
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt  = rem2;
        dq_nxt   = {dq_r[SW-3:0], ge1, ge2};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DW'(DIV_STEPS - 1)) begin
          state_nxt = ST_M0;
        end
      end
      ST_M0: begin
        prod_nxt  = mul_p;
        state_nxt = ST_M1;
      end
      ST_M1: begin
        acc_nxt   = prod_r;
        prod_nxt  = mul_p;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        low_nxt   = low_r + prod_fold;
        prod_nxt  = mul_p;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        acc_nxt   = prod_r;
        prod_nxt  = mul_p;
        state_nxt = ST_M4;
      end
      ST_M4: begin
        range_nxt = prod_fold;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold one byte back so the final one can carry tlast
        if (out_free) begin
          if (go) begin
            if (pend_v_r) begin
              ov_nxt   = 1'b1;
              ob_nxt   = pend_r;
              ol_nxt   = 1'b0;
              obad_nxt = 1'b0;
            end
            pend_nxt   = low_r[SW-1:SW-BW];
            pend_v_nxt = 1'b1;
            low_nxt    = low_r << BW;
            range_nxt  = rng_use << BW;
            n_nxt      = n_r + 1'b1;
          end else begin
            if (pend_v_r) begin
              ov_nxt   = 1'b1;
              ob_nxt   = pend_r;
              ol_nxt   = 1'b1;
              obad_nxt = 1'b0;
            end
            pend_v_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          ob_nxt   = low_r[SW-1:SW-BW];
          ol_nxt   = (n_r == NW'(crenc64_pkg::MAX_EMIT - 1));
          obad_nxt = 1'b0;
          low_nxt  = low_r << BW;
          n_nxt    = n_r + 1'b1;
          if (n_r == NW'(crenc64_pkg::MAX_EMIT - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BAD: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = '0;
          ol_nxt    = 1'b0;
          obad_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      low_r    <= '0;
      range_r  <= '1;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      low_r    <= low_nxt;
      range_r  <= range_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    n_r    <= n_nxt;
    pend_r <= pend_nxt;
    cmd_r  <= cmd_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
    obad_r <= obad_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = obad_r;

endmodule

// ===== hdl/carryless_range_encoder_64_top.sv =====
// ----------------------------------------------------------------------------
// carryless_range_encoder_64_top
// Carryless 64-bit range encoder with streaming input and byte output.
// ----------------------------------------------------------------------------
// Input channel (in_*): one transaction per item. in_tuser selects encode (0)
// or flush (1); in_tdata carries symbol_low, symbol_high and total_count.
// Output channel (out_*): one transaction per emitted byte on out_tdata;
// out_tlast marks the final byte of an item, out_tuser marks a rejected item
// (one transaction, data zero, tlast low).
// A two-entry command queue sits between the checking front end and the
// execution back end, so input is taken while the back end is busy.
// Encode: the item is dequeued, the range is divided by the total in a
// radix-4 division loop, the shared 32x32 multiplier forms the new low and
// range (states M0 to M4), then bytes are emitted. Flush emits all eight
// bytes of low, a rejected item one marker. Division sets the encode rate.
// Reset (rst_n low, synchronous) sets low to zero and range to all ones and
// empties the queue and the output register. When out_tready is low the back
// end holds at the next byte; the queue fills and then in_tready drops.
// ----------------------------------------------------------------------------
module carryless_range_encoder_64_top #(
  parameter int TOP_BIT    = crenc64_pkg::TOP_BIT_DEF,
  parameter int BOTTOM_BIT = crenc64_pkg::BOTTOM_BIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] symbol_low, [63:32] symbol_high, [95:64] total_count
  input  logic [3*crenc64_pkg::COUNT_W-1:0]  in_tdata,
  // [0] opcode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] out_byte
  output logic [crenc64_pkg::BYTE_W-1:0]     out_tdata,
  output logic                               out_tlast,
  // [0] bad_item
  output logic                               out_tuser
);

  logic              q_valid;
  logic              q_ready;
  crenc64_pkg::cmd_t q_cmd;

  crenc64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  crenc64_back #(
    .TOP_BIT    (TOP_BIT),
    .BOTTOM_BIT (BOTTOM_BIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
